// File: src/otc_pkg.sv
package otc_pkg;

  // ASCII codes used by the decoder
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChThree = 8'h33;
  localparam logic [7:0] ChFour  = 8'h34;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7a;
  localparam logic [7:0] ChP     = 8'h50;

  // Count-byte characters skipped after the header pair
  localparam logic [1:0] SkipCount = 2'd2;
  // Index of the last character of a group
  localparam logic [1:0] GroupLast = 2'd3;

  // System letters indexed by the top two bits of the first hex digit
  localparam logic [7:0] SystemLetters [4] = '{8'h50, 8'h43, 8'h42, 8'h55};

  // Input word
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } otc_in_t;

  // Result word
  typedef struct packed {
    logic       is_code;
    logic [7:0] system_letter;
    logic [7:0] system_digit;
    logic [7:0] code_char_a;
    logic [7:0] code_char_b;
    logic [7:0] code_char_c;
    logic       end_of_response;
  } otc_out_t;

  // Operation passed from front to back
  typedef struct packed {
    logic       has_code;
    logic       has_end;
    logic [7:0] g0;
    logic [7:0] g1;
    logic [7:0] g2;
    logic [7:0] g3;
  } otc_op_t;

  // Fold a..z to upper case
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= ChLowA && c <= ChLowZ) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

endpackage

// File: src/obd_trouble_code_extractor.sv
// Trouble code extractor for mode 03 response text.
// Input channel: push a word {ch, last} while full is low; one character per
// cycle is accepted. Spaces are dropped, letters folded, text before the
// first "43" pair and the two count characters after it are ignored, and
// every following group of four characters other than "0000" yields a code.
// Result channel: while empty is low the oldest result word is on result;
// pop takes it. A word with last set yields an end-of-response word after
// any code it completes.
// A result passes from the op queue, written at the edge that accepts the
// character causing it, into the output register, from which pop takes it.
// Throughput: one character per cycle in while full is low, one result per
// cycle out while pop is high; a final character that also completes a code
// yields two result words, and the op queue of QUEUE_DEPTH entries absorbs
// that and any receiver stall.
// When the receiver stalls the output register holds, the queue fills and
// full rises; no word is lost.
// Reset (rst, synchronous) clears the header search, the group position
// and empties the queue and output register.
module obd_trouble_code_extractor #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  otc_pkg::otc_in_t   item,
  output logic               empty,
  input  logic               pop,
  output otc_pkg::otc_out_t  result
);
  import otc_pkg::*;

  logic    take;
  logic    op_push;
  otc_op_t op_in;
  logic    op_valid;
  logic    op_pop;
  otc_op_t op_out;

  assign take = push && !full;

  // Front: header search, count skip, grouping
  otc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (item),
    .op_push (op_push),
    .op      (op_in)
  );

  // Op queue between front and back
  otc_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (op_push),
    .wr_data  (op_in),
    .full     (full),
    .rd_en    (op_pop),
    .rd_valid (op_valid),
    .rd_data  (op_out)
  );

  // Back: code decode and result register
  otc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op_out),
    .op_pop   (op_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

// File: src/otc_front.sv
module otc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  otc_pkg::otc_in_t item,
  output logic             op_push,
  output otc_pkg::otc_op_t op
);
  import otc_pkg::*;

  logic       header_seen, header_seen_next;
  logic [7:0] previous_char, previous_char_next;
  logic [1:0] count_skip_left, count_skip_left_next;
  logic [1:0] group_position, group_position_next;
  logic [7:0] group_chars [3];
  logic [7:0] c;
  logic       store_char;
  logic       code_hit;

  // Classify the character and compute next search/group state
  always_comb begin
    c                    = fold_upper(item.ch);
    header_seen_next     = header_seen;
    previous_char_next   = previous_char;
    count_skip_left_next = count_skip_left;
    group_position_next  = group_position;
    store_char           = 1'b0;
    code_hit             = 1'b0;
    if (c != ChSpace) begin
      if (!header_seen) begin
        if (previous_char == ChFour && c == ChThree) begin
          header_seen_next     = 1'b1;
          count_skip_left_next = SkipCount;
        end else begin
          previous_char_next = c;
        end
      end else if (count_skip_left != 2'd0) begin
        count_skip_left_next = count_skip_left - 2'd1;
      end else if (group_position != GroupLast) begin
        store_char          = 1'b1;
        group_position_next = group_position + 2'd1;
      end else begin
        group_position_next = 2'd0;
        code_hit = !(group_chars[0] == ChZero && group_chars[1] == ChZero &&
                     group_chars[2] == ChZero && c == ChZero);
      end
    end
  end

  // Op word to the queue
  always_comb begin
    op.has_code = code_hit;
    op.has_end  = item.last;
    op.g0       = group_chars[0];
    op.g1       = group_chars[1];
    op.g2       = group_chars[2];
    op.g3       = c;
    op_push     = take && (code_hit || item.last);
  end

  // Control state; the last character returns it to reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      header_seen     <= 1'b0;
      previous_char   <= 8'd0;
      count_skip_left <= SkipCount;
      group_position  <= 2'd0;
    end else if (take) begin
      if (item.last) begin
        header_seen     <= 1'b0;
        previous_char   <= 8'd0;
        count_skip_left <= SkipCount;
        group_position  <= 2'd0;
      end else begin
        header_seen     <= header_seen_next;
        previous_char   <= previous_char_next;
        count_skip_left <= count_skip_left_next;
        group_position  <= group_position_next;
      end
    end
  end

  // Group characters, written before read within a group
  always_ff @(posedge clk) begin
    if (take && store_char) begin
      group_chars[group_position] <= c;
    end
  end

endmodule

// File: src/otc_fifo.sv
module otc_fifo #(
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  otc_pkg::otc_op_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output otc_pkg::otc_op_t rd_data
);
  import otc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(Depth);

  otc_op_t         slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr, do_rd;

  assign full     = (count == CntMax);
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrMax) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrMax) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: src/otc_back.sv
module otc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_valid,
  input  otc_pkg::otc_op_t op,
  output logic             op_pop,
  output logic             empty,
  input  logic             pop,
  output otc_pkg::otc_out_t result
);
  import otc_pkg::*;

  logic       out_valid;
  logic       code_sent;
  logic       load;
  logic       emit_code;
  logic [3:0] hex_v;
  logic       hex_ok;
  otc_out_t   word_next;

  // Hex value of the group's first character
  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (op.g0 >= ChZero && op.g0 <= ChNine) begin
      hex_v = 4'(op.g0 - ChZero);
    end else if (op.g0 >= ChUpA && op.g0 <= ChUpF) begin
      hex_v = 4'(op.g0 - ChUpA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Pick the next result word: code first, then end marker
  always_comb begin
    load      = !out_valid || pop;
    emit_code = op.has_code && !code_sent;
    word_next = '0;
    if (emit_code) begin
      word_next.is_code       = 1'b1;
      word_next.system_letter = hex_ok ? SystemLetters[hex_v[3:2]] : ChP;
      word_next.system_digit  = hex_ok ? (ChZero + {6'd0, hex_v[1:0]}) : ChZero;
      word_next.code_char_a   = op.g1;
      word_next.code_char_b   = op.g2;
      word_next.code_char_c   = op.g3;
    end else begin
      word_next.end_of_response = 1'b1;
    end
    op_pop = load && op_valid && !(emit_code && op.has_end);
  end

  assign empty = !out_valid;

  // Output register and per-op progress
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      code_sent <= 1'b0;
    end else if (load) begin
      out_valid <= op_valid;
      if (op_valid) begin
        code_sent <= emit_code && op.has_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && op_valid) begin
      result <= word_next;
    end
  end

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import otc_pkg::*;

  // known-count marker: take the expectation from the decoder model
  localparam int Predicted = -1;
  localparam int CycleLimit = 400000;
  localparam int RandomItems = 1550;
  localparam otc_out_t EndWord = '{end_of_response: 1'b1, default: '0};

  logic     clk;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  logic     full;
  logic     empty;
  otc_in_t  item = '0;
  otc_out_t result;

  obd_trouble_code_extractor u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // directed stimulus row: word plus optional hand-written expectation
  typedef struct {
    otc_in_t  w;
    int       n_known;
    otc_out_t k0;
    otc_out_t k1;
  } plan_row_t;

  plan_row_t plan[$];
  otc_in_t   resp_words[$];
  otc_out_t  dtc_expected[$];

  int       errors = 0;
  int       cycles = 0;
  int       kept_items = 0;
  int       pop_stall = 0;
  bit       idle_on = 1'b1;
  int       known_n = Predicted;
  otc_out_t known_w[2];

  // decoder model state
  bit         hdr_found;
  logic [7:0] prev_kept;
  logic [1:0] count_left;
  logic [7:0] grp[3];
  logic [1:0] grp_len;

  function automatic void clear_decoder();
    hdr_found = 1'b0;
    prev_kept = 8'h00;
    count_left = SkipCount;
    grp_len = 2'd0;
    foreach (grp[i]) grp[i] = 8'h00;
  endfunction

  // hex value of an upper-case hex digit, 16 when not a hex digit
  function automatic int hex_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return 16;
  endfunction

  function automatic otc_out_t code_word(logic [7:0] l, logic [7:0] d, logic [7:0] a,
                                         logic [7:0] b, logic [7:0] c);
    otc_out_t r;
    r = '0;
    r.is_code = 1'b1;
    r.system_letter = l;
    r.system_digit = d;
    r.code_char_a = a;
    r.code_char_b = b;
    r.code_char_c = c;
    return r;
  endfunction

  // decode one character; returns the result words it causes
  function automatic void predict_dtc(input otc_in_t w, output int n, output otc_out_t o[2]);
    logic [7:0] c;
    logic [7:0] letters[4];
    int v;
    letters = '{"P", "C", "B", "U"};
    n = 0;
    o[0] = '0;
    o[1] = '0;
    c = w.ch;
    if (c >= "a" && c <= "z") c = c - 8'd32;
    if (c != " ") begin
      if (!hdr_found) begin
        if (prev_kept == "4" && c == "3") begin
          hdr_found = 1'b1;
          count_left = SkipCount;
        end else begin
          prev_kept = c;
        end
      end else if (count_left != 0) begin
        count_left = count_left - 2'd1;
      end else if (grp_len < 3) begin
        grp[grp_len] = c;
        grp_len = grp_len + 2'd1;
      end else begin
        grp_len = 2'd0;
        // an all-zero group is padding, not a code
        if (!(grp[0] == "0" && grp[1] == "0" && grp[2] == "0" && c == "0")) begin
          v = hex_of(grp[0]);
          if (v < 16) begin
            o[n] = code_word(letters[v / 4], 8'h30 + 8'(v % 4), grp[1], grp[2], c);
          end else begin
            o[n] = code_word("P", "0", grp[1], grp[2], c);
          end
          n++;
        end
      end
    end
    if (w.last) begin
      o[n] = EndWord;
      n++;
      clear_decoder();
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] e, logic [7:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", name, e, a);
      errors++;
    end
  endfunction

  // accept words, predict, and score result words
  always @(posedge clk) begin
    int       n;
    otc_out_t ow[2];
    otc_out_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else if (!rst) begin
      if (push && !full) begin
        predict_dtc(item, n, ow);
        if (known_n != Predicted) begin
          for (int i = 0; i < known_n; i++)
            dtc_expected.insert(dtc_expected.size(), known_w[i]);
        end else begin
          for (int i = 0; i < n; i++) dtc_expected.insert(dtc_expected.size(), ow[i]);
        end
      end
      if (pop && !empty) begin
        if (dtc_expected.size() == 0) begin
          $error("result word with nothing expected: %h", result);
          errors++;
        end else begin
          want = dtc_expected.pop_front();
          check_field("is_code", 8'(want.is_code), 8'(result.is_code));
          check_field("system_letter", want.system_letter, result.system_letter);
          check_field("system_digit", want.system_digit, result.system_digit);
          check_field("code_char_a", want.code_char_a, result.code_char_a);
          check_field("code_char_b", want.code_char_b, result.code_char_b);
          check_field("code_char_c", want.code_char_c, result.code_char_c);
          check_field("end_of_response", 8'(want.end_of_response),
                      8'(result.end_of_response));
        end
      end
    end
  end

  // receiver: pop with random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_stall > 0) begin
      pop_stall--;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      pop_stall = $urandom_range(1, 19) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic send(otc_in_t w, int n, otc_out_t k0, otc_out_t k1);
    int gap;
    // no idling in a middle window and at the tail of the run
    idle_on = !(kept_items >= 1350 || (kept_items >= 500 && kept_items < 650));
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
    end
    @(negedge clk);
    push <= 1'b1;
    item <= w;
    known_n = n;
    known_w[0] = k0;
    known_w[1] = k1;
    do @(posedge clk); while (full);
    kept_items++;
  endtask

  // stop sending until every expected word has been popped
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (dtc_expected.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(logic [7:0] c, bit l, int n, otc_out_t k0, otc_out_t k1);
    plan_row_t r;
    r.w = '{ch: c, last: l};
    r.n_known = n;
    r.k0 = k0;
    r.k1 = k1;
    plan.insert(plan.size(), r);
  endtask

  function automatic logic [7:0] rand_hex();
    logic [7:0] c;
    int v;
    v = $urandom_range(0, 15);
    c = (v < 10) ? 8'h30 + 8'(v) : "A" + 8'(v - 10);
    // lower-case letters half the time
    if (v >= 10 && $urandom_range(0, 1) == 1) c = c + 8'd32;
    return c;
  endfunction

  function automatic void add_char(logic [7:0] c);
    if ($urandom_range(0, 11) == 0)
      resp_words.insert(resp_words.size(), '{ch: " ", last: 1'b0});
    resp_words.insert(resp_words.size(), '{ch: c, last: 1'b0});
  endfunction

  // one response text: mostly well formed, some noise and broken headers
  function automatic void build_response();
    int kind;
    int style;
    resp_words.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 12))
        resp_words.insert(resp_words.size(),
                          '{ch: 8'($urandom_range(0, 255)),
                            last: ($urandom_range(0, 15) == 0)});
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 2))
        0: add_char(8'($urandom_range(0, 255)));
        1: add_char("4");
        default: add_char(8'($urandom_range(8'h21, 8'h7e)));
      endcase
    end
    if (kind >= 20) begin
      add_char("4");
      add_char("3");
    end else begin
      // broken header
      add_char($urandom_range(0, 1) ? "3" : "4");
      add_char("4");
    end
    add_char(rand_hex());
    add_char(rand_hex());
    repeat ($urandom_range(0, 5)) begin
      style = $urandom_range(0, 9);
      for (int i = 0; i < 4; i++) begin
        case (style)
          0, 1: add_char("0");
          2: add_char(8'($urandom_range(0, 255)));
          3: add_char(i == 0 ? 8'($urandom_range(0, 255)) : rand_hex());
          default: add_char(rand_hex());
        endcase
      end
    end
    // partial trailing group
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) add_char(rand_hex());
    if ($urandom_range(0, 4) == 0)
      resp_words.insert(resp_words.size(), '{ch: " ", last: 1'b0});
    resp_words[resp_words.size() - 1].last = 1'b1;
  endfunction

  // main sequence
  initial begin
    clear_decoder();
    // final char with no header; sliding header; space; count chars;
    // lower case; zero group; non-hex first char; extremes; last completes a
    // group; space as final char
    add_row(8'hFF, 1'b1, 1, EndWord, '0);
    add_row("4", 1'b0, Predicted, '0, '0);
    add_row("4", 1'b0, Predicted, '0, '0);
    add_row("3", 1'b0, Predicted, '0, '0);
    add_row(" ", 1'b0, Predicted, '0, '0);
    add_row("0", 1'b0, Predicted, '0, '0);
    add_row("2", 1'b0, Predicted, '0, '0);
    add_row("c", 1'b0, Predicted, '0, '0);
    add_row("1", 1'b0, Predicted, '0, '0);
    add_row("a", 1'b0, Predicted, '0, '0);
    add_row("f", 1'b0, 1, code_word("U", "0", "1", "A", "F"), '0);
    add_row("0", 1'b0, Predicted, '0, '0);
    add_row("0", 1'b0, Predicted, '0, '0);
    add_row("0", 1'b0, Predicted, '0, '0);
    add_row("0", 1'b0, 0, '0, '0);
    add_row("8", 1'b0, Predicted, '0, '0);
    add_row("b", 1'b0, Predicted, '0, '0);
    add_row("0", 1'b0, Predicted, '0, '0);
    add_row("0", 1'b0, Predicted, '0, '0);
    add_row("z", 1'b0, Predicted, '0, '0);
    add_row(8'hFF, 1'b0, Predicted, '0, '0);
    add_row(8'h00, 1'b0, Predicted, '0, '0);
    add_row("7", 1'b1, 2, code_word("P", "0", 8'hFF, 8'h00, "7"), EndWord);
    add_row(" ", 1'b1, 1, EndWord, '0);

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send(plan[i].w, plan[i].n_known, plan[i].k0, plan[i].k1);
    drain();

    kept_items = 0;
    while (kept_items < RandomItems) begin
      build_response();
      foreach (resp_words[i]) send(resp_words[i], Predicted, '0, '0);
      if (kept_items >= 900 && kept_items < 1000) drain();
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
